FILE: hdl/gig_pkg.sv
// ----------------------------------------------------------------------------
// gig_pkg
// shared types and constants of the greedy interval grouping block
// ----------------------------------------------------------------------------
package gig_pkg;

    localparam int BOUND_W = 32;
    localparam int TAG_W   = 16;
    localparam int CNT_W   = 13;
    localparam int IN_W    = 80;
    localparam int OUT_W   = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_DECIDE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_rd;
        logic decide;
    } cmd_t;

    typedef struct packed {
        logic fast;
        logic scan_done;
    } status_t;

endpackage

FILE: hdl/gig_ctrl.sv
// ----------------------------------------------------------------------------
// gig_ctrl
// controller sequencing load, table scan, decision and result transfer
// ----------------------------------------------------------------------------
module gig_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output gig_pkg::cmd_t    cmd,
    input  gig_pkg::status_t status
);
    import gig_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.fast)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = (state_reg == ST_IDLE);
        out_valid   = (state_reg == ST_OUT);
        cmd.load    = (state_reg == ST_IDLE) && in_valid;
        cmd.scan_rd = (state_reg == ST_SCAN) || (state_reg == ST_WAIT);
        cmd.decide  = (state_reg == ST_DECIDE);
    end

endmodule

FILE: hdl/gig_dp.sv
// ----------------------------------------------------------------------------
// gig_dp
// datapath: range table memory, overlap scan, run state and counters
// ----------------------------------------------------------------------------
module gig_dp
#(
    parameter int MAX_ACCEPT = 256,
    parameter int MAX_ITEMS  = 4096
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [gig_pkg::BOUND_W-1:0]   range_begin,
    input  logic [gig_pkg::BOUND_W-1:0]   range_end,
    input  logic [gig_pkg::TAG_W-1:0]     rule_tag,
    input  logic                          set_last,
    input  logic                          out_done,
    input  gig_pkg::cmd_t                 cmd,
    output gig_pkg::status_t              status,
    output logic [gig_pkg::OUT_W-1:0]     result
);
    import gig_pkg::*;

    localparam int AW = (MAX_ACCEPT > 1) ? $clog2(MAX_ACCEPT) : 1;
    localparam int CW = $clog2(MAX_ACCEPT + 1);
    localparam int CAP_I = (MAX_ITEMS < 8191) ? MAX_ITEMS : 8191;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(CAP_I);

    logic [2*BOUND_W-1:0] mem [MAX_ACCEPT];

    logic [BOUND_W-1:0] b_reg, e_reg, lo_reg, hi_reg, pb_reg, pe_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic               last_reg;
    logic [CW-1:0]      cnt_reg;
    logic               pverd_reg, first_reg;
    logic [CNT_W-1:0]   ar_reg, rr_reg, ai_reg;
    logic [CW-1:0]      rd_idx_reg;
    logic               rd_v_reg;
    logic [2*BOUND_W-1:0] rd_reg;
    logic               hit_reg;
    logic               acc_reg, start_reg, full_reg;
    logic               repeat_w, miss_bounds, acc_next_w;

    assign repeat_w    = (b_reg == pb_reg) && (e_reg == pe_reg);
    assign miss_bounds = !(b_reg <= hi_reg && e_reg >= lo_reg);
    assign status.fast = first_reg || repeat_w || miss_bounds || (cnt_reg == '0);
    assign status.scan_done = !rd_v_reg && (rd_idx_reg >= cnt_reg);

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v < CAP) ? v + 1'b1 : v;
    endfunction

    // table read: one entry per cycle, registered
    always_ff @(posedge clk)
    begin
        rd_reg <= mem[rd_idx_reg[AW-1:0]];
        if (cmd.decide && acc_next_w && !first_reg && !repeat_w)
        begin
            mem[cnt_reg[AW-1:0]] <= {b_reg, e_reg};
        end
        else if (cmd.decide && first_reg)
        begin
            mem[0] <= {b_reg, e_reg};
        end
    end

    assign acc_next_w = first_reg ? 1'b1 :
                        repeat_w ? pverd_reg :
                        (!hit_reg && !miss_bounds) || miss_bounds ?
                            (cnt_reg < CW'(MAX_ACCEPT)) : 1'b0;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            b_reg    <= range_begin;
            e_reg    <= range_end;
            tag_reg  <= rule_tag;
            last_reg <= set_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg <= '0;
            rd_v_reg   <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else if (cmd.load)
        begin
            rd_idx_reg <= '0;
            rd_v_reg   <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else if (cmd.scan_rd)
        begin
            rd_v_reg <= (rd_idx_reg < cnt_reg);
            if (rd_idx_reg < cnt_reg)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            if (rd_v_reg && b_reg <= rd_reg[BOUND_W-1:0] &&
                e_reg >= rd_reg[2*BOUND_W-1:BOUND_W])
            begin
                hit_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0; lo_reg <= '0; hi_reg <= '0; pb_reg <= '0; pe_reg <= '0;
            pverd_reg <= 1'b0; first_reg <= 1'b1;
            ar_reg <= '0; rr_reg <= '0; ai_reg <= '0;
            acc_reg <= 1'b0; start_reg <= 1'b0; full_reg <= 1'b0;
        end
        else if (cmd.decide)
        begin
            acc_reg   <= acc_next_w;
            start_reg <= !(!first_reg && repeat_w);
            full_reg  <= !first_reg && !repeat_w && (!hit_reg || miss_bounds) &&
                         (cnt_reg >= CW'(MAX_ACCEPT));
            pb_reg    <= b_reg;
            pe_reg    <= e_reg;
            pverd_reg <= acc_next_w;
            if (first_reg)
            begin
                first_reg <= 1'b0;
                cnt_reg   <= CW'(1);
                lo_reg    <= b_reg;
                hi_reg    <= e_reg;
                ar_reg    <= bump('0);
                rr_reg    <= '0;
                ai_reg    <= bump('0);
            end
            else if (repeat_w)
            begin
                if (pverd_reg)
                begin
                    ai_reg <= bump(ai_reg);
                end
            end
            else if (acc_next_w)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (b_reg < lo_reg) lo_reg <= b_reg;
                if (e_reg > hi_reg) hi_reg <= e_reg;
                ar_reg <= bump(ar_reg);
                ai_reg <= bump(ai_reg);
            end
            else
            begin
                rr_reg <= bump(rr_reg);
            end
        end
        else if (out_done && last_reg)
        begin
            cnt_reg <= '0; lo_reg <= '0; hi_reg <= '0; pb_reg <= '0; pe_reg <= '0;
            pverd_reg <= 1'b0; first_reg <= 1'b1;
            ar_reg <= '0; rr_reg <= '0; ai_reg <= '0;
        end
    end

    assign result = {5'b00000, last_reg, full_reg, ai_reg, rr_reg, ar_reg,
                     start_reg, acc_reg, tag_reg};

endmodule

FILE: hdl/greedy_interval_grouping.sv
// ----------------------------------------------------------------------------
// greedy_interval_grouping
// greedy selection of non-overlapping ranges with a scanned range table
// ----------------------------------------------------------------------------
// sequence: without a table scan the item passes the scan, decide and output
// states; otherwise scan and wait read the table, one read per cycle, before decide
// throughput: one item at a time; the next item is taken in the cycle after
// the result transfer
// reset: asynchronous, clears the set state; the table needs no clearing
module greedy_interval_grouping
#(
    parameter int MAX_ACCEPT = 256,
    parameter int MAX_ITEMS  = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // range_begin, range_end, rule_tag
    input  logic        s_tlast,   // set_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // rule_tag_out, accepted, run_start,
                                   // accepted_runs, rejected_runs,
                                   // accepted_items, table_full, zero pad
    output logic        m_tlast    // result_last
);
    import gig_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic [OUT_W-1:0] res;

    gig_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .status    (status)
    );

    gig_dp #(.MAX_ACCEPT(MAX_ACCEPT), .MAX_ITEMS(MAX_ITEMS)) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .range_begin (s_tdata[31:0]),
        .range_end   (s_tdata[63:32]),
        .rule_tag    (s_tdata[79:64]),
        .set_last    (s_tlast),
        .out_done    (m_tvalid && m_tready),
        .cmd         (cmd),
        .status      (status),
        .result      (res)
    );

    assign m_tdata = {6'b000000, res[57:0]};
    assign m_tlast = res[58];

endmodule
